>>> rtl/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the rank queue
// Word formats, operation and status codes, sequencer states and the sizing
// helpers of the tail read-out tree.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int DEPTH_DEFAULT   = 512;
   localparam int ID_BITS_DEFAULT = 16;
   localparam int RANK_W          = 32;
   localparam int LIMIT_W         = 10;
   localparam int OCC_W           = 10;
   localparam int ID_FIELD_W      = 16;
   localparam int FANIN_LOG       = 3;
   localparam int FANIN           = 1 << FANIN_LOG;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;
   localparam logic [RANK_W-1:0]  EMPTY_RANK  = 32'd99999999;

   typedef logic [1:0] op_code_type;
   localparam op_code_type OP_PUSH      = 2'd0;
   localparam op_code_type OP_POP_FRONT = 2'd1;
   localparam op_code_type OP_POP_BACK  = 2'd2;

   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_ITEM  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_EVICT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_code_type             op;
      logic [RANK_W-1:0]       rank;
      logic [ID_FIELD_W-1:0]   item_id;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [ID_FIELD_W-1:0]   out_id;
      logic [RANK_W-1:0]       out_rank;
      logic [OCC_W-1:0]        occupancy;
      logic [RANK_W-1:0]       max_rank;
   } rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                    push;
      logic                    shift;
      logic [RANK_W-1:0]       rank;
   } cell_ctrl_type;

   // Number of nodes on a given level of the read-out tree (level 0 = leaves).
   function automatic int tree_level_size(input int n, input int level);
      int s;
      s = n;
      for (int l = 0; l < level; l++) begin
         s = (s + FANIN - 1) >> FANIN_LOG;
      end
      return s;
   endfunction

   // Registered levels needed to bring n leaves down to one node.
   function automatic int tree_levels(input int n);
      int s;
      int l;
      s = n;
      l = 0;
      while (s > 1) begin
         s = (s + FANIN - 1) >> FANIN_LOG;
         l = l + 1;
      end
      return (l < 1) ? 1 : l;
   endfunction

endpackage

>>> rtl/prq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell: one slot of the sorted chain
// Holds one rank and handle. On a push it keeps its entry, takes the new one
// or takes its left neighbor's; on a front pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module prq_cell #(
   parameter int ID_BITS = prq_pkg::ID_BITS_DEFAULT
) (
   input  logic                          clock,
   input  prq_pkg::cell_ctrl_type        ctrl,
   input  logic [ID_BITS-1:0]            push_id,
   input  logic                          occupied,
   input  logic                          left_keep,
   input  logic [prq_pkg::RANK_W-1:0]    left_rank,
   input  logic [ID_BITS-1:0]            left_id,
   input  logic [prq_pkg::RANK_W-1:0]    right_rank,
   input  logic [ID_BITS-1:0]            right_id,
   output logic                          keep,
   output logic [prq_pkg::RANK_W-1:0]    rank_ff,
   output logic [ID_BITS-1:0]            id_ff
);

   logic [prq_pkg::RANK_W-1:0] rank_in;
   logic [ID_BITS-1:0]         id_in;

   // Equal ranks stay ahead of the new entry, which keeps arrival order.
   assign keep = occupied && (rank_ff <= ctrl.rank);

   always_comb begin
      rank_in = rank_ff;
      id_in   = id_ff;
      priority if (ctrl.push) begin
         if (keep) begin
            rank_in = rank_ff;
            id_in   = id_ff;
         end else if (left_keep) begin
            rank_in = ctrl.rank;
            id_in   = push_id;
         end else begin
            rank_in = left_rank;
            id_in   = left_id;
         end
      end else if (ctrl.shift) begin
         rank_in = right_rank;
         id_in   = right_id;
      end else begin
         rank_in = rank_ff;
         id_in   = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      id_ff   <= id_in;
   end

endmodule

>>> rtl/prq_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_or_tree: registered OR-reduction tree
// At most one leaf per bit position is nonzero, so the OR of all leaves
// reads out the selected entry. One register level per fan-in stage.
// ----------------------------------------------------------------------------
module prq_or_tree #(
   parameter int N     = prq_pkg::DEPTH_DEFAULT + 1,
   parameter int WIDTH = 2 * (prq_pkg::RANK_W + prq_pkg::ID_BITS_DEFAULT)
) (
   input  logic                     clock,
   input  logic [N-1:0][WIDTH-1:0]  leaves,
   output logic [WIDTH-1:0]         tree_out
);

   localparam int LEVELS = prq_pkg::tree_levels(N);
   localparam int MAX_SZ = prq_pkg::tree_level_size(N, 1);

   logic [WIDTH-1:0] node_ff [1:LEVELS][0:MAX_SZ-1];

   for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
      localparam int SZ  = prq_pkg::tree_level_size(N, l);
      localparam int PSZ = prq_pkg::tree_level_size(N, l - 1);
      for (genvar j = 0; j < SZ; j++) begin : g_node
         logic [prq_pkg::FANIN-1:0][WIDTH-1:0] kids;
         logic [WIDTH-1:0]                     or_sum;
         for (genvar k = 0; k < prq_pkg::FANIN; k++) begin : g_kid
            if (j * prq_pkg::FANIN + k >= PSZ) begin : g_pad
               assign kids[k] = '0;
            end else if (l == 1) begin : g_leaf
               assign kids[k] = leaves[j * prq_pkg::FANIN + k];
            end else begin : g_inner
               assign kids[k] = node_ff[l-1][j * prq_pkg::FANIN + k];
            end
         end
         always_comb begin
            or_sum = '0;
            for (int k = 0; k < prq_pkg::FANIN; k++) begin
               or_sum = or_sum | kids[k];
            end
         end
         always_ff @(posedge clock) begin
            node_ff[l][j] <= or_sum;
         end
      end
   end

   assign tree_out = node_ff[LEVELS][0];

endmodule

>>> rtl/pifo_rank_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifo_rank_queue: push-in first-out queue sorted by rank
// A chain of DEPTH+1 cells keeps handles in ascending rank order; a
// registered tree reads out the tail of the chain.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a command word on req_word while busy is low; the word
//   is taken at that edge. Push inserts the entry at its sorted place, pop
//   front returns the head, pop back returns the tail. A push that takes the
//   occupancy above the capacity limit evicts and reports the tail entry.
//   Exactly one result word per command appears on rsp_word for one cycle
//   with rsp_valid high; the receiver cannot hold it off.
//   Sequence: the chain updates at the accept edge, then the tail read-out
//   tree takes L = ceil(log8(DEPTH+1)) registered levels (4 for DEPTH 512),
//   and the result is shown in the following cycle. busy stays high from
//   the accept until the result cycle ends, so no new command is taken
//   before then; the depth of the read-out tree sets how long that is.
//   csr_we with csr_wdata writes the capacity limit, at any time the block
//   is idle. Reset empties the queue and sets the limit to 500; the cell
//   storage itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pifo_rank_queue #(
   parameter int DEPTH   = prq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = prq_pkg::ID_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  prq_pkg::req_type             req_word,
   output logic                         rsp_valid,
   output prq_pkg::rsp_type             rsp_word,
   input  logic                         csr_we,
   input  logic [prq_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int CELLS  = DEPTH + 1;
   localparam int CNT_W  = $clog2(DEPTH + 3);
   localparam int CMP_W  = ((CNT_W > prq_pkg::LIMIT_W) ? CNT_W : prq_pkg::LIMIT_W) + 1;
   localparam int HALF_W = prq_pkg::RANK_W + ID_BITS;
   localparam int LEAF_W = 2 * HALF_W;
   localparam int LEVELS = prq_pkg::tree_levels(CELLS);
   localparam int WCNT_W = $clog2(LEVELS + 1);

   prq_pkg::state_type            state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [WCNT_W-1:0]             wait_cnt_ff, wait_cnt_in;
   logic [prq_pkg::LIMIT_W-1:0]   limit_ff;
   prq_pkg::status_type           status_ff, status_in;
   logic                          drop_ff, drop_in;
   logic                          use_front_ff, use_front_in;
   logic [prq_pkg::RANK_W-1:0]    front_rank_ff;
   logic [ID_BITS-1:0]            front_id_ff;

   logic                          accept;
   logic                          empty;
   logic                          push_drop;
   prq_pkg::cell_ctrl_type        cell_ctrl;
   logic [ID_BITS-1:0]            push_id;

   logic [prq_pkg::RANK_W-1:0]    cell_rank [0:CELLS-1];
   logic [ID_BITS-1:0]            cell_id   [0:CELLS-1];
   logic                          cell_keep [0:CELLS-1];
   logic [CELLS-1:0][LEAF_W-1:0]  leaves;
   logic [LEAF_W-1:0]             tree_out;

   logic [prq_pkg::RANK_W-1:0]    tail_rank, prev_rank;
   logic [ID_BITS-1:0]            tail_id;
   logic [CNT_W-1:0]              final_count;

   assign accept    = start && !busy;
   assign empty     = (count_ff == '0);
   // The limit acts as min(limit, DEPTH).
   assign push_drop = (CMP_W'(count_ff) >= CMP_W'(limit_ff)) ||
                      (count_ff >= CNT_W'(DEPTH));
   assign push_id   = ID_BITS'(req_word.item_id);

   assign cell_ctrl.push  = accept && (req_word.op == prq_pkg::OP_PUSH);
   assign cell_ctrl.shift = accept && (req_word.op == prq_pkg::OP_POP_FRONT) && !empty;
   assign cell_ctrl.rank  = req_word.rank;

   // Chain of cells; each also offers its entry to the tail read-out tree
   // when it sits at the last or second-to-last occupied place.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic                        occupied;
      logic                        left_keep;
      logic [prq_pkg::RANK_W-1:0]  left_rank, right_rank;
      logic [ID_BITS-1:0]          left_id, right_id;
      logic                        sel_last, sel_prev;

      assign occupied = (count_ff > CNT_W'(i));
      assign sel_last = (count_ff == CNT_W'(i + 1));
      assign sel_prev = (count_ff == CNT_W'(i + 2));

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_rank = cell_ctrl.rank;
         assign left_id   = push_id;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_rank = cell_rank[i-1];
         assign left_id   = cell_id[i-1];
      end

      if (i == CELLS - 1) begin : g_tail
         assign right_rank = cell_rank[i];
         assign right_id   = cell_id[i];
      end else begin : g_link
         assign right_rank = cell_rank[i+1];
         assign right_id   = cell_id[i+1];
      end

      prq_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .push_id    (push_id),
         .occupied   (occupied),
         .left_keep  (left_keep),
         .left_rank  (left_rank),
         .left_id    (left_id),
         .right_rank (right_rank),
         .right_id   (right_id),
         .keep       (cell_keep[i]),
         .rank_ff    (cell_rank[i]),
         .id_ff      (cell_id[i])
      );

      assign leaves[i] = {(sel_last ? {cell_rank[i], cell_id[i]} : {HALF_W{1'b0}}),
                          (sel_prev ? {cell_rank[i], cell_id[i]} : {HALF_W{1'b0}})};
   end

   prq_or_tree #(
      .N     (CELLS),
      .WIDTH (LEAF_W)
   ) u_tree (
      .clock    (clock),
      .leaves   (leaves),
      .tree_out (tree_out)
   );

   assign tail_rank = tree_out[LEAF_W-1 -: prq_pkg::RANK_W];
   assign tail_id   = tree_out[HALF_W +: ID_BITS];
   assign prev_rank = tree_out[HALF_W-1 -: prq_pkg::RANK_W];

   // Command decode at the accept edge.
   always_comb begin
      status_in    = status_ff;
      drop_in      = drop_ff;
      use_front_in = use_front_ff;
      if (accept) begin
         drop_in      = 1'b0;
         use_front_in = 1'b0;
         unique case (req_word.op)
            prq_pkg::OP_PUSH: begin
               drop_in   = push_drop;
               status_in = push_drop ? prq_pkg::ST_EVICT : prq_pkg::ST_NONE;
            end
            prq_pkg::OP_POP_FRONT: begin
               use_front_in = !empty;
               status_in    = empty ? prq_pkg::ST_EMPTY : prq_pkg::ST_ITEM;
            end
            prq_pkg::OP_POP_BACK: begin
               drop_in   = !empty;
               status_in = empty ? prq_pkg::ST_EMPTY : prq_pkg::ST_ITEM;
            end
            default: begin
               status_in = prq_pkg::ST_NONE;
            end
         endcase
      end
   end

   // The count first follows the chain; a tail removal takes one off at the end.
   always_comb begin
      count_in = count_ff;
      priority if (cell_ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cell_ctrl.shift) begin
         count_in = count_ff - CNT_W'(1);
      end else if (state_ff == prq_pkg::S_FINISH && drop_ff) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in    = state_ff;
      wait_cnt_in = wait_cnt_ff;
      unique case (state_ff)
         prq_pkg::S_IDLE: begin
            if (accept) begin
               state_in    = prq_pkg::S_WAIT;
               wait_cnt_in = '0;
            end
         end
         prq_pkg::S_WAIT: begin
            wait_cnt_in = wait_cnt_ff + WCNT_W'(1);
            if (wait_cnt_ff == WCNT_W'(LEVELS - 1)) begin
               state_in = prq_pkg::S_FINISH;
            end
         end
         prq_pkg::S_FINISH: begin
            state_in = prq_pkg::S_IDLE;
         end
         default: begin
            state_in = prq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy        = (state_ff != prq_pkg::S_IDLE);
      rsp_valid   = (state_ff == prq_pkg::S_FINISH);
      final_count = drop_ff ? (count_ff - CNT_W'(1)) : count_ff;
      rsp_word.status    = status_ff;
      rsp_word.occupancy = prq_pkg::OCC_W'(final_count);
      priority if (drop_ff) begin
         rsp_word.out_id   = prq_pkg::ID_FIELD_W'(tail_id);
         rsp_word.out_rank = tail_rank;
      end else if (use_front_ff) begin
         rsp_word.out_id   = prq_pkg::ID_FIELD_W'(front_id_ff);
         rsp_word.out_rank = front_rank_ff;
      end else begin
         rsp_word.out_id   = '0;
         rsp_word.out_rank = '0;
      end
      if (final_count == '0) begin
         rsp_word.max_rank = prq_pkg::EMPTY_RANK;
      end else begin
         rsp_word.max_rank = drop_ff ? prq_pkg::RANK_W'(prev_rank) : tail_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::S_IDLE;
         count_ff     <= '0;
         wait_cnt_ff  <= '0;
         limit_ff     <= prq_pkg::LIMIT_RESET;
         status_ff    <= prq_pkg::ST_NONE;
         drop_ff      <= 1'b0;
         use_front_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_cnt_ff  <= wait_cnt_in;
         status_ff    <= status_in;
         drop_ff      <= drop_in;
         use_front_ff <= use_front_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_rank_ff <= cell_rank[0];
         front_id_ff   <= cell_id[0];
      end
   end

`ifndef SYNTHESIS
   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word shown while the block is idle");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("more than one result word for a command");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("command accepted without entering the busy phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (count_ff <= CNT_W'(DEPTH)))
      else $error("occupancy above the queue depth while idle");
`endif

endmodule

>>> verif/prq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_order_checker: answer checker for the rank queue
// Watches the command, answer and capacity ports, keeps its own sorted copy
// of the queue, predicts the answer word for every accepted command and
// compares each answer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module prq_order_checker #(
   parameter int DEPTH   = prq_pkg::DEPTH_DEFAULT,
   parameter int ID_BITS = prq_pkg::ID_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  prq_pkg::req_type             req_word,
   input  logic                         rsp_valid,
   input  prq_pkg::rsp_type             rsp_word,
   input  logic                         csr_we,
   input  logic [prq_pkg::LIMIT_W-1:0]  csr_wdata,
   output int                           mismatches,
   output int                           answers_pending,
   output int                           answers_seen,
   output int                           evictions_seen,
   output int                           empties_seen
);

   localparam int MAX_PRINTED = 40;
   localparam logic [prq_pkg::ID_FIELD_W-1:0] HANDLE_MASK =
      (ID_BITS >= prq_pkg::ID_FIELD_W) ? '1 :
      prq_pkg::ID_FIELD_W'((1 << ID_BITS) - 1);

   typedef struct packed {
      logic [prq_pkg::RANK_W-1:0]      rank;
      logic [prq_pkg::ID_FIELD_W-1:0]  handle;
   } held_entry_type;

   held_entry_type               held[$];
   prq_pkg::rsp_type             answers_due[$];
   logic [prq_pkg::LIMIT_W-1:0]  cap_limit;

   // Removes the last entry of the local queue copy and returns it.
   function automatic held_entry_type take_tail();
      held_entry_type t;
      t = held[$];
      held.delete(held.size() - 1);
      return t;
   endfunction

   // Applies one command to the local queue copy and returns the answer word.
   function automatic prq_pkg::rsp_type sorted_queue_answer(input prq_pkg::req_type w);
      prq_pkg::rsp_type  r;
      held_entry_type    e;
      int                k;
      int                lim;
      r = '0;
      r.status = prq_pkg::ST_NONE;
      lim = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
      case (w.op)
         prq_pkg::OP_PUSH: begin
            // Equal ranks keep arrival order, so the new entry goes behind them.
            k = 0;
            while (k < held.size() && held[k].rank <= w.rank) k++;
            e.rank = w.rank;
            e.handle = w.item_id & HANDLE_MASK;
            held.insert(k, e);
            if (held.size() > lim) begin
               e = take_tail();
               r.status = prq_pkg::ST_EVICT;
               r.out_id = e.handle;
               r.out_rank = e.rank;
            end
         end
         prq_pkg::OP_POP_FRONT, prq_pkg::OP_POP_BACK: begin
            if (held.size() == 0) begin
               r.status = prq_pkg::ST_EMPTY;
            end else begin
               e = (w.op == prq_pkg::OP_POP_FRONT) ? held.pop_front() : take_tail();
               r.status = prq_pkg::ST_ITEM;
               r.out_id = e.handle;
               r.out_rank = e.rank;
            end
         end
         default: ;
      endcase
      r.occupancy = prq_pkg::OCC_W'(held.size());
      r.max_rank = (held.size() == 0) ? prq_pkg::EMPTY_RANK : held[$].rank;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("%0t: answer %0d, %s got %0h, want %0h", $time, answers_seen, what,
                  got, want);
      end
   endtask

   task automatic compare_answer(input prq_pkg::rsp_type got, input prq_pkg::rsp_type want);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.out_id !== want.out_id) report_mismatch("out_id", got.out_id, want.out_id);
      if (got.out_rank !== want.out_rank) begin
         report_mismatch("out_rank", got.out_rank, want.out_rank);
      end
      if (got.occupancy !== want.occupancy) begin
         report_mismatch("occupancy", got.occupancy, want.occupancy);
      end
      if (got.max_rank !== want.max_rank) begin
         report_mismatch("max_rank", got.max_rank, want.max_rank);
      end
   endtask

   initial begin
      mismatches = 0;
      answers_seen = 0;
      evictions_seen = 0;
      empties_seen = 0;
      answers_pending = 0;
      cap_limit = prq_pkg::LIMIT_RESET;
   end

   always @(posedge clock) begin : watch
      prq_pkg::rsp_type want;
      if (reset) begin
         held.delete();
         answers_due.delete();
         cap_limit = prq_pkg::LIMIT_RESET;
         answers_pending <= 0;
      end else begin
         // An answer at this edge belongs to a command accepted earlier, so it
         // is matched before any command taken at the same edge.
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected word, status", rsp_word.status, '0);
            end else begin
               want = answers_due.pop_front();
               compare_answer(rsp_word, want);
               if (want.status == prq_pkg::ST_EVICT) evictions_seen++;
               if (want.status == prq_pkg::ST_EMPTY) empties_seen++;
            end
            answers_seen++;
         end
         if (csr_we) cap_limit = csr_wdata;
         if (start && !busy) begin
            answers_due.insert(answers_due.size(), sorted_queue_answer(req_word));
         end
         answers_pending <= answers_due.size();
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the rank queue
// Drives directed and random push/pop command words with random gaps through
// several capacity settings (zero, small, above depth) and lets the order
// checker predict and compare every answer word.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam prq_pkg::op_code_type OP_UNUSED = 2'd3;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   prq_pkg::req_type             req_word;
   logic                         rsp_valid;
   prq_pkg::rsp_type             rsp_word;
   logic                         csr_we;
   logic [prq_pkg::LIMIT_W-1:0]  csr_wdata;

   int   mismatches;
   int   answers_pending;
   int   answers_seen;
   int   evictions_seen;
   int   empties_seen;
   int   words_sent = 0;
   int   settings_used = 1;
   int   quiet_cycles = 0;
   logic steady = 1'b0;

   always #5 clock = ~clock;

   pifo_rank_queue dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   prq_order_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_word        (rsp_word),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .answers_pending (answers_pending),
      .answers_seen    (answers_seen),
      .evictions_seen  (evictions_seen),
      .empties_seen    (empties_seen)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic prq_pkg::req_type command(input prq_pkg::op_code_type op,
                                                input logic [prq_pkg::RANK_W-1:0] rank,
                                                input logic [prq_pkg::ID_FIELD_W-1:0] item_id);
      prq_pkg::req_type w;
      w.op = op;
      w.rank = rank;
      w.item_id = item_id;
      return w;
   endfunction

   // Small ranks in 40 of 100 picks so that ties are common, extremes in 10, the rest wide.
   function automatic logic [prq_pkg::RANK_W-1:0] pick_rank();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return prq_pkg::RANK_W'($urandom_range(0, 15));
      if (roll < 50) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return prq_pkg::EMPTY_RANK;
            default: return prq_pkg::EMPTY_RANK + 1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [prq_pkg::ID_FIELD_W-1:0] pick_handle();
      return prq_pkg::ID_FIELD_W'($urandom_range(0, 65535));
   endfunction

   // Called at the edge that took the previous word (or after reset); returns
   // at the edge that takes this one.
   task automatic issue(input prq_pkg::req_type w);
      if (!steady && $urandom_range(0, 99) < 27) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
   endtask

   task automatic set_limit(input logic [prq_pkg::LIMIT_W-1:0] value);
      drain();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_mix(input int count, input int push_pct);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct) begin
            issue(command(prq_pkg::OP_PUSH, pick_rank(), pick_handle()));
         end else if (roll < push_pct + 3) begin
            issue(command(OP_UNUSED, $urandom, pick_handle()));
         end else if ($urandom_range(0, 1) == 0) begin
            issue(command(prq_pkg::OP_POP_FRONT, $urandom, pick_handle()));
         end else begin
            issue(command(prq_pkg::OP_POP_BACK, $urandom, pick_handle()));
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, unused code, extreme ranks and handles, ties.
      issue(command(prq_pkg::OP_POP_FRONT, '1, '1));
      issue(command(prq_pkg::OP_POP_BACK, '1, '1));
      issue(command(OP_UNUSED, '1, '1));
      issue(command(prq_pkg::OP_PUSH, '0, '0));
      issue(command(prq_pkg::OP_PUSH, '1, '1));
      issue(command(prq_pkg::OP_PUSH, 32'd5, 16'h0001));
      issue(command(prq_pkg::OP_PUSH, 32'd5, 16'h0002));
      issue(command(prq_pkg::OP_PUSH, 32'd5, 16'h0003));
      issue(command(prq_pkg::OP_PUSH, prq_pkg::EMPTY_RANK, 16'h8000));
      issue(command(prq_pkg::OP_PUSH, '0, 16'h7fff));
      issue(command(OP_UNUSED, '0, '0));
      issue(command(prq_pkg::OP_POP_FRONT, '0, '0));
      issue(command(prq_pkg::OP_POP_FRONT, '0, '0));
      issue(command(prq_pkg::OP_POP_BACK, '0, '0));
      issue(command(prq_pkg::OP_POP_FRONT, '0, '0));
      issue(command(prq_pkg::OP_POP_BACK, '0, '0));
      issue(command(prq_pkg::OP_POP_BACK, '0, '0));
      issue(command(prq_pkg::OP_POP_FRONT, '0, '0));
      issue(command(prq_pkg::OP_POP_FRONT, '0, '0));
      issue(command(prq_pkg::OP_PUSH, 32'haaaaaaaa, 16'haaaa));
      issue(command(prq_pkg::OP_PUSH, 32'h55555555, 16'h5555));
      issue(command(prq_pkg::OP_POP_BACK, '0, '0));

      set_limit(10'd4);
      random_mix(250, 60);
      // With a zero limit every push evicts, and the occupancy left from the
      // previous setting may sit above the limit.
      set_limit(10'd0);
      random_mix(40, 70);
      // Above the depth the limit acts as the depth; fill to it without gaps.
      set_limit(10'd1023);
      steady = 1'b1;
      random_mix(530, 100);
      steady = 1'b0;
      random_mix(80, 30);
      set_limit(10'd37);
      random_mix(250, 55);
      set_limit(10'd512);
      random_mix(100, 50);
      set_limit(10'd1);
      random_mix(60, 40);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d command words over %0d capacity settings (zero, one, above depth).",
               words_sent, settings_used);
      $display("Checked %0d answer words: %0d evictions, %0d empty pops, %0d mismatches.",
               answers_seen, evictions_seen, empties_seen, mismatches);
      if (mismatches == 0 && answers_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
